// ===== hw/rtl/arp_pkg.sv =====
// Shared types, codes and constants of the ARP proxy responder.
package arp_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int PORT_COUNT_DEF    = 4;

   localparam int PORT_W = 2;
   localparam int IP_W   = 32;
   localparam int MAC_W  = 48;

   localparam logic [1:0] FUNC_FRAME  = 2'd0;
   localparam logic [1:0] FUNC_ADD    = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;

   localparam logic [2:0] ST_REPLY    = 3'd0;
   localparam logic [2:0] ST_INVALID  = 3'd1;
   localparam logic [2:0] ST_NOMATCH  = 3'd2;
   localparam logic [2:0] ST_WRITTEN  = 3'd3;
   localparam logic [2:0] ST_REMOVED  = 3'd4;
   localparam logic [2:0] ST_NOTFOUND = 3'd5;
   localparam logic [2:0] ST_FULL     = 3'd6;

   localparam logic [4:0]  FRAME_BYTES     = 5'd28;
   localparam logic [15:0] HWTYPE_ETHERNET = 16'h0001;
   localparam logic [15:0] PROTO_IPV4      = 16'h0800;
   localparam logic [7:0]  HW_ADDR_LEN     = 8'd6;
   localparam logic [7:0]  PROTO_ADDR_LEN  = 8'd4;
   localparam logic [15:0] OP_REQUEST      = 16'h0001;
   localparam logic [15:0] OP_REPLY        = 16'h0002;

   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic [IP_W-1:0]   ip;
   } key_type;

   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic [IP_W-1:0]   ip;
      logic [MAC_W-1:0]  mac;
   } entry_type;

endpackage

// ===== hw/rtl/arp_proxy_responder_top.sv =====
// ARP proxy responder: table sequencer, slot scan and result register.
// Sequence: a table scan reads the slots through the registered read port and compares each,
// ending early when a slot matches; rejected requests skip the scan and go to the result register.
// Requests are taken one at a time, limited by the single table read port scanned one slot per
// cycle; one new request is taken while a result waits.
// Reset: all slots marked free at once, no clearing pass; control state cleared.
module arp_proxy_responder_top import arp_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int PORT_COUNT    = PORT_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [1:0]  req_port_index,
   input  logic [4:0]  req_frame_length,
   input  logic [15:0] req_hw_type,
   input  logic [15:0] req_proto_type,
   input  logic [7:0]  req_hw_addr_len,
   input  logic [7:0]  req_proto_addr_len,
   input  logic [15:0] req_opcode,
   input  logic [47:0] req_requester_mac,
   input  logic [31:0] req_requester_ip,
   input  logic [31:0] req_target_ip,
   input  logic [47:0] req_entry_mac,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_out_port,
   output logic [47:0] rsp_reply_sender_mac,
   output logic [31:0] rsp_reply_sender_ip,
   output logic [47:0] rsp_reply_target_mac,
   output logic [31:0] rsp_reply_target_ip
);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_type;
   typedef enum logic [2:0] {K_FRAME, K_ADD, K_REMOVE, K_INVALID, K_NOTFOUND} kind_type;

   state_type               state_ff, state_in;
   kind_type                kind_ff, kind_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [IW-1:0]           scan_ff, scan_in;
   logic                    issued_ff, issued_in;
   logic [IW-1:0]           chk_idx_ff, chk_idx_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic                    hit_ff, hit_in;
   logic [IW-1:0]           hit_idx_ff, hit_idx_in;
   logic [MAC_W-1:0]        hit_mac_ff, hit_mac_in;
   logic                    free_found_ff, free_found_in;
   logic [IW-1:0]           free_idx_ff, free_idx_in;

   logic [PORT_W-1:0]       port_ff, port_in;
   logic [IP_W-1:0]         tgt_ip_ff, tgt_ip_in;
   logic [MAC_W-1:0]        req_mac_ff, req_mac_in;
   logic [IP_W-1:0]         req_ip_ff, req_ip_in;
   logic [MAC_W-1:0]        new_mac_ff, new_mac_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              rsp_status_ff, rsp_status_in;
   logic [PORT_W-1:0]       rsp_port_ff, rsp_port_in;
   logic [MAC_W-1:0]        rsp_smac_ff, rsp_smac_in;
   logic [IP_W-1:0]         rsp_sip_ff, rsp_sip_in;
   logic [MAC_W-1:0]        rsp_tmac_ff, rsp_tmac_in;
   logic [IP_W-1:0]         rsp_tip_ff, rsp_tip_in;

   logic                    accept;
   logic                    port_ok;
   logic                    frame_ok;
   logic                    rd_en;
   logic                    wr_en;
   logic [IW-1:0]           wr_addr;
   entry_type               wr_entry;
   entry_type               rd_entry;
   key_type                 key;
   logic                    slot_hit;
   logic                    out_free;

   arp_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (scan_ff),
      .rd_data (rd_entry)
   );

   assign key.port = port_ff;
   assign key.ip   = tgt_ip_ff;

   arp_cmp u_cmp (
      .entry       (rd_entry),
      .entry_valid (chk_vld_ff && valid_ff[chk_idx_ff]),
      .key         (key),
      .hit         (slot_hit)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign port_ok   = 32'(req_port_index) < 32'(PORT_COUNT);
   assign frame_ok  = (req_frame_length == FRAME_BYTES) && (req_hw_type == HWTYPE_ETHERNET) &&
                      (req_proto_type == PROTO_IPV4) && (req_hw_addr_len == HW_ADDR_LEN) &&
                      (req_proto_addr_len == PROTO_ADDR_LEN) && (req_opcode == OP_REQUEST);
   assign rd_en     = (state_ff == S_SCAN) && !issued_ff;

   assign wr_entry.port = port_ff;
   assign wr_entry.ip   = tgt_ip_ff;
   assign wr_entry.mac  = new_mac_ff;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      valid_in      = valid_ff;
      scan_in       = scan_ff;
      issued_in     = issued_ff;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = 1'b0;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_mac_in    = hit_mac_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      port_in       = port_ff;
      tgt_ip_in     = tgt_ip_ff;
      req_mac_in    = req_mac_ff;
      req_ip_in     = req_ip_ff;
      new_mac_in    = new_mac_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_smac_in   = rsp_smac_ff;
      rsp_sip_in    = rsp_sip_ff;
      rsp_tmac_in   = rsp_tmac_ff;
      rsp_tip_in    = rsp_tip_ff;
      wr_en         = 1'b0;
      wr_addr       = hit_idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               port_in       = req_port_index;
               tgt_ip_in     = req_target_ip;
               req_mac_in    = req_requester_mac;
               req_ip_in     = req_requester_ip;
               new_mac_in    = req_entry_mac;
               scan_in       = '0;
               issued_in     = 1'b0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               case (req_func)
                  FUNC_FRAME:  kind_in = (frame_ok && port_ok) ? K_FRAME : K_INVALID;
                  FUNC_ADD:    kind_in = port_ok ? K_ADD : K_NOTFOUND;
                  FUNC_REMOVE: kind_in = port_ok ? K_REMOVE : K_NOTFOUND;
                  default:     kind_in = K_INVALID;
               endcase
               if (kind_in == K_INVALID || kind_in == K_NOTFOUND) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (!issued_ff) begin
               chk_idx_in = scan_ff;
               chk_vld_in = 1'b1;
               if (!free_found_ff && !valid_ff[scan_ff]) begin
                  free_found_in = 1'b1;
                  free_idx_in   = scan_ff;
               end
               if (scan_ff == LAST_IDX) begin
                  issued_in = 1'b1;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
            if (slot_hit) begin
               hit_in     = 1'b1;
               hit_idx_in = chk_idx_ff;
               hit_mac_in = rd_entry.mac;
               chk_vld_in = 1'b0;
               state_in   = S_FINISH;
            end else if (chk_vld_ff && chk_idx_ff == LAST_IDX) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_port_in   = '0;
               rsp_smac_in   = '0;
               rsp_sip_in    = '0;
               rsp_tmac_in   = '0;
               rsp_tip_in    = '0;
               case (kind_ff)
                  K_FRAME: begin
                     if (hit_ff) begin
                        rsp_status_in = ST_REPLY;
                        rsp_port_in   = port_ff;
                        rsp_smac_in   = hit_mac_ff;
                        rsp_sip_in    = tgt_ip_ff;
                        rsp_tmac_in   = req_mac_ff;
                        rsp_tip_in    = req_ip_ff;
                     end else begin
                        rsp_status_in = ST_NOMATCH;
                     end
                  end
                  K_ADD: begin
                     if (hit_ff || free_found_ff) begin
                        wr_en           = 1'b1;
                        wr_addr         = hit_ff ? hit_idx_ff : free_idx_ff;
                        valid_in[wr_addr] = 1'b1;
                        rsp_status_in   = ST_WRITTEN;
                     end else begin
                        rsp_status_in = ST_FULL;
                     end
                  end
                  K_REMOVE: begin
                     if (hit_ff) begin
                        valid_in[hit_idx_ff] = 1'b0;
                        rsp_status_in        = ST_REMOVED;
                     end else begin
                        rsp_status_in = ST_NOTFOUND;
                     end
                  end
                  K_NOTFOUND: rsp_status_in = ST_NOTFOUND;
                  default:    rsp_status_in = ST_INVALID;
               endcase
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= K_INVALID;
         valid_ff     <= '0;
         issued_ff    <= 1'b0;
         chk_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         valid_ff     <= valid_in;
         issued_ff    <= issued_in;
         chk_vld_ff   <= chk_vld_in;
         hit_ff       <= hit_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff       <= scan_in;
      chk_idx_ff    <= chk_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_mac_ff    <= hit_mac_in;
      free_idx_ff   <= free_idx_in;
      port_ff       <= port_in;
      tgt_ip_ff     <= tgt_ip_in;
      req_mac_ff    <= req_mac_in;
      req_ip_ff     <= req_ip_in;
      new_mac_ff    <= new_mac_in;
      rsp_status_ff <= rsp_status_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_smac_ff   <= rsp_smac_in;
      rsp_sip_ff    <= rsp_sip_in;
      rsp_tmac_ff   <= rsp_tmac_in;
      rsp_tip_ff    <= rsp_tip_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_out_port         = rsp_port_ff;
   assign rsp_reply_sender_mac = rsp_smac_ff;
   assign rsp_reply_sender_ip  = rsp_sip_ff;
   assign rsp_reply_target_mac = rsp_tmac_ff;
   assign rsp_reply_target_ip  = rsp_tip_ff;

endmodule

// ===== hw/rtl/arp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module arp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/arp_cmp.sv =====
// Slot compare unit: matches one stored entry against the lookup key.
module arp_cmp import arp_pkg::*; (
   input  entry_type entry,
   input  logic      entry_valid,
   input  key_type   key,
   output logic      hit
);

   assign hit = entry_valid && (entry.port == key.port) && (entry.ip == key.ip);

endmodule
